### rtl/core/ltrsm_pkg.sv
`default_nettype none

package ltrsm_pkg;

    // Default number of slots in the ring
    localparam int LTR_SLOT_COUNT = 4;

    // Slot index width carried by the scan token (covers up to 16 slots)
    localparam int LTR_IDX_W = 4;

    // Request codes
    typedef enum logic [1:0] {
        REQ_MARK    = 2'd0,
        REQ_INVAL   = 2'd1,
        REQ_REFRESH = 2'd2,
        REQ_PICTURE = 2'd3
    } req_t;

    // Configuration register indexes
    localparam logic CFG_SLOTS   = 1'b0;
    localparam logic CFG_REFRESH = 1'b1;

    // Broadcast controls from the sequencer to every slot cell
    typedef struct packed {
        logic        clear_all;
        logic        kill_all;
        logic [31:0] threshold;
        logic [31:0] wr_frame;
    } cell_ctl_t;

    // Scan token handed from cell to cell during an invalidate
    typedef struct packed {
        logic                 active;
        logic                 found;
        logic [31:0]          best_id;
        logic [LTR_IDX_W-1:0] best_idx;
    } scan_tok_t;

endpackage

`default_nettype wire

### rtl/core/ltrsm_cell.sv
`default_nettype none

module ltrsm_cell
    import ltrsm_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      wr_en,
    input  wire logic      scan_en,
    input  wire scan_tok_t scan_in,
    output scan_tok_t      scan_out
);

    logic [31:0] frame_reg;
    logic [31:0] frame_next;
    logic        valid_reg;
    logic        valid_next;
    scan_tok_t   tok_reg;
    scan_tok_t   tok_next;

    logic hit;
    logic drop;
    logic better;

    // Token visits this slot: drop it if at or above threshold, else compete
    assign hit    = scan_in.active && scan_en && valid_reg;
    assign drop   = hit && (frame_reg >= ctl.threshold);
    assign better = hit && !drop && (!scan_in.found || (frame_reg > scan_in.best_id));

    always_comb
    begin
        tok_next = scan_in;
        if (better)
        begin
            tok_next.found    = 1'b1;
            tok_next.best_id  = frame_reg;
            tok_next.best_idx = LTR_IDX_W'(IDX);
        end
    end

    // Slot contents; a commit write wins over a keyframe flush
    always_comb
    begin
        frame_next = frame_reg;
        valid_next = valid_reg;
        if (ctl.clear_all)
        begin
            frame_next = 32'd0;
            valid_next = 1'b0;
        end
        else if (wr_en)
        begin
            frame_next = ctl.wr_frame;
            valid_next = 1'b1;
        end
        else if (ctl.kill_all || drop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Frame id is only read while valid
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign scan_out = tok_reg;

endmodule

`default_nettype wire

### rtl/core/long_term_reference_slot_manager_unit.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  req_type, frame_id, refresh_frames,
//                                           force_keyframe, picture_accepted
// out       output     out_valid/out_stall  accepted, use_ltr, use_mask,
//                                           refresh_count, mark_ltr, mark_slot
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time: mark, refresh and picture go from idle straight to done,
// and the result is registered at commit; an invalidate with slots in use first
// waits in the scan state while the scan token walks the slot cells from the accept cycle on.
// A new item is taken while the previous result waits on out_stall; its result
// then waits for the output register. Register writes wait while in_valid is high.
// Reset (rst_n, asynchronous) empties all slots and pending settings.
`default_nettype none

module long_term_reference_slot_manager_unit
    import ltrsm_pkg::*;
#(
    parameter int SLOT_COUNT = LTR_SLOT_COUNT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [31:0] frame_id,
    input  wire logic [15:0] refresh_frames,
    input  wire logic        force_keyframe,
    input  wire logic        picture_accepted,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic             use_ltr,
    output logic [3:0]       use_mask,
    output logic [15:0]      refresh_count,
    output logic             mark_ltr,
    output logic [1:0]       mark_slot,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [2:0]  cfg_data
);

    localparam int IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NW  = ($clog2(SLOT_COUNT + 1) > 3) ? $clog2(SLOT_COUNT + 1) : 3;
    localparam int MW  = (SLOT_COUNT > 4) ? SLOT_COUNT : 4;
    localparam int XW  = (IW > 2) ? IW : 2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Latched item
    req_t        req_reg;
    logic [31:0] fid_reg;
    logic [15:0] frames_reg;
    logic        kf_reg;
    logic        pic_ok_reg;

    // Configuration
    logic [2:0]  slots_reg;
    logic [2:0]  slots_next;
    logic        refresh_sup_reg;
    logic        refresh_sup_next;

    // Ring and pending settings
    logic [IW-1:0] next_slot_reg;
    logic [IW-1:0] next_slot_next;
    logic          mark_pend_reg;
    logic          mark_pend_next;
    logic [IW-1:0] mark_slot_pend_reg;
    logic [IW-1:0] mark_slot_pend_next;
    logic [31:0]   mark_frame_pend_reg;
    logic [31:0]   mark_frame_pend_next;
    logic          use_pend_reg;
    logic          use_pend_next;
    logic [3:0]    use_mask_pend_reg;
    logic [3:0]    use_mask_pend_next;
    logic [15:0]   refresh_pend_reg;
    logic [15:0]   refresh_pend_next;

    // Scan result
    logic                 found_reg;
    logic                 found_next;
    logic [LTR_IDX_W-1:0] best_idx_reg;
    logic [LTR_IDX_W-1:0] best_idx_next;

    // Output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        ok_reg;
    logic        ok_next;
    logic        use_ltr_reg;
    logic        use_ltr_next;
    logic [3:0]  use_mask_reg;
    logic [3:0]  use_mask_next;
    logic [15:0] refresh_cnt_reg;
    logic [15:0] refresh_cnt_next;
    logic        mark_ltr_reg;
    logic        mark_ltr_next;
    logic [1:0]  mark_slot_reg;
    logic [1:0]  mark_slot_next;

    logic          in_acc;
    logic          cfg_wr;
    logic          start;
    logic          out_free;
    logic          commit;
    logic          commit_pic_ok;
    logic [NW-1:0] slots_ext;
    logic [NW-1:0] n_act;
    logic [IW-1:0] cur_slot;
    logic [NW-1:0] cur_plus;
    logic [IW-1:0] next_ring;
    logic [MW-1:0] onehot_w;
    logic [XW-1:0] mslot_ext;
    logic          scan_done;
    cell_ctl_t     ctl;
    scan_tok_t     tok [0:SLOT_COUNT];

    // Handshakes; a register write never shares an edge with an item
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == ST_DONE) && out_free;
    assign commit_pic_ok = commit && (req_reg == REQ_PICTURE) && pic_ok_reg;

    // Effective slot count and ring advance
    assign slots_ext = NW'(slots_reg);
    assign n_act     = (slots_ext > NW'(SLOT_COUNT)) ? NW'(SLOT_COUNT) : slots_ext;
    assign cur_slot  = (NW'(next_slot_reg) < n_act) ? next_slot_reg : '0;
    assign cur_plus  = NW'(cur_slot) + NW'(1);
    assign next_ring = (cur_plus == n_act) ? '0 : cur_plus[IW-1:0];

    assign start = in_acc && (req_t'(req_type) == REQ_INVAL) && (n_act != '0);

    assign onehot_w  = MW'(1) << best_idx_reg;
    assign mslot_ext = XW'(mark_slot_pend_reg);

    // Broadcast controls to the cells; cell 0 sees the threshold in the accept cycle
    always_comb
    begin
        ctl.clear_all = cfg_wr && (cfg_index == CFG_SLOTS);
        ctl.kill_all  = commit_pic_ok && kf_reg;
        ctl.threshold = start ? frame_id : fid_reg;
        ctl.wr_frame  = mark_frame_pend_reg;
    end

    // Token enters cell 0 when an invalidate starts
    always_comb
    begin
        tok[0].active   = start;
        tok[0].found    = 1'b0;
        tok[0].best_id  = 32'd0;
        tok[0].best_idx = '0;
    end

    // Row of slot cells
    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_cell
        ltrsm_cell #(
            .IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .wr_en    (commit_pic_ok && mark_pend_reg && (mark_slot_pend_reg == IW'(g))),
            .scan_en  (NW'(g) < n_act),
            .scan_in  (tok[g]),
            .scan_out (tok[g+1])
        );
    end

    assign scan_done = tok[SLOT_COUNT].active;

    // Sequencer, commit and configuration
    always_comb
    begin
        state_next           = state_reg;
        slots_next           = slots_reg;
        refresh_sup_next     = refresh_sup_reg;
        next_slot_next       = next_slot_reg;
        mark_pend_next       = mark_pend_reg;
        mark_slot_pend_next  = mark_slot_pend_reg;
        mark_frame_pend_next = mark_frame_pend_reg;
        use_pend_next        = use_pend_reg;
        use_mask_pend_next   = use_mask_pend_reg;
        refresh_pend_next    = refresh_pend_reg;
        found_next           = found_reg;
        best_idx_next        = best_idx_reg;
        out_valid_next       = out_valid_reg;
        ok_next              = ok_reg;
        use_ltr_next         = use_ltr_reg;
        use_mask_next        = use_mask_reg;
        refresh_cnt_next     = refresh_cnt_reg;
        mark_ltr_next        = mark_ltr_reg;
        mark_slot_next       = mark_slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = start ? ST_SCAN : ST_DONE;
                    found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next    = ST_DONE;
                    found_next    = tok[SLOT_COUNT].found;
                    best_idx_next = tok[SLOT_COUNT].best_idx;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Result and state update for the item
        if (commit)
        begin
            out_valid_next   = 1'b1;
            ok_next          = 1'b0;
            use_ltr_next     = 1'b0;
            use_mask_next    = 4'd0;
            refresh_cnt_next = 16'd0;
            mark_ltr_next    = 1'b0;
            mark_slot_next   = 2'd0;
            case (req_reg)
                REQ_MARK:
                begin
                    if (n_act != '0)
                    begin
                        mark_slot_pend_next  = cur_slot;
                        next_slot_next       = next_ring;
                        mark_frame_pend_next = fid_reg;
                        mark_pend_next       = 1'b1;
                        ok_next              = 1'b1;
                    end
                end
                REQ_INVAL:
                begin
                    if (found_reg)
                    begin
                        use_pend_next      = 1'b1;
                        use_mask_pend_next = onehot_w[3:0];
                        ok_next            = 1'b1;
                    end
                end
                REQ_REFRESH:
                begin
                    if (refresh_sup_reg && (frames_reg != 16'd0))
                    begin
                        refresh_pend_next = frames_reg;
                        ok_next           = 1'b1;
                    end
                end
                REQ_PICTURE:
                begin
                    use_ltr_next     = use_pend_reg;
                    use_mask_next    = use_pend_reg ? use_mask_pend_reg : 4'd0;
                    refresh_cnt_next = refresh_pend_reg;
                    mark_ltr_next    = mark_pend_reg;
                    mark_slot_next   = mark_pend_reg ? mslot_ext[1:0] : 2'd0;
                    ok_next          = pic_ok_reg;
                    if (pic_ok_reg)
                    begin
                        use_pend_next      = 1'b0;
                        use_mask_pend_next = 4'd0;
                        refresh_pend_next  = 16'd0;
                        mark_pend_next     = 1'b0;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Register writes, only taken while idle
        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_SLOTS:
                begin
                    slots_next     = cfg_data;
                    next_slot_next = '0;
                end
                CFG_REFRESH:
                begin
                    refresh_sup_next = cfg_data[0];
                end
                default:
                begin
                    slots_next = slots_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            slots_reg           <= 3'd0;
            refresh_sup_reg     <= 1'b0;
            next_slot_reg       <= '0;
            mark_pend_reg       <= 1'b0;
            mark_slot_pend_reg  <= '0;
            mark_frame_pend_reg <= 32'd0;
            use_pend_reg        <= 1'b0;
            use_mask_pend_reg   <= 4'd0;
            refresh_pend_reg    <= 16'd0;
            found_reg           <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            slots_reg           <= slots_next;
            refresh_sup_reg     <= refresh_sup_next;
            next_slot_reg       <= next_slot_next;
            mark_pend_reg       <= mark_pend_next;
            mark_slot_pend_reg  <= mark_slot_pend_next;
            mark_frame_pend_reg <= mark_frame_pend_next;
            use_pend_reg        <= use_pend_next;
            use_mask_pend_reg   <= use_mask_pend_next;
            refresh_pend_reg    <= refresh_pend_next;
            found_reg           <= found_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg    <= req_t'(req_type);
            fid_reg    <= frame_id;
            frames_reg <= refresh_frames;
            kf_reg     <= force_keyframe;
            pic_ok_reg <= picture_accepted;
        end
        best_idx_reg    <= best_idx_next;
        ok_reg          <= ok_next;
        use_ltr_reg     <= use_ltr_next;
        use_mask_reg    <= use_mask_next;
        refresh_cnt_reg <= refresh_cnt_next;
        mark_ltr_reg    <= mark_ltr_next;
        mark_slot_reg   <= mark_slot_next;
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = ok_reg;
    assign use_ltr       = use_ltr_reg;
    assign use_mask      = use_mask_reg;
    assign refresh_count = refresh_cnt_reg;
    assign mark_ltr      = mark_ltr_reg;
    assign mark_slot     = mark_slot_reg;

endmodule

`default_nettype wire

### rtl/core/ltrsm_checker.sv
`default_nettype none

module ltrsm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        accepted,
    input wire logic        use_ltr,
    input wire logic [3:0]  use_mask,
    input wire logic [15:0] refresh_count,
    input wire logic        mark_ltr,
    input wire logic [1:0]  mark_slot
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(accepted) && $stable(use_ltr)
            && $stable(use_mask) && $stable(refresh_count) && $stable(mark_ltr)
            && $stable(mark_slot))
        else $error("result changed while stalled");

    // One item in flight: input closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while one is in flight");

    // No use selected means an empty mask; a selected mask is at most one-hot
    a_use_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (use_ltr ? $onehot0(use_mask) : (use_mask == 4'd0)))
        else $error("bad use mask");

    // No mark means slot zero
    a_mark_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mark_ltr |-> mark_slot == 2'd0)
        else $error("mark slot set without mark");

endmodule

bind long_term_reference_slot_manager_unit ltrsm_checker u_ltrsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .use_ltr       (use_ltr),
    .use_mask      (use_mask),
    .refresh_count (refresh_count),
    .mark_ltr      (mark_ltr),
    .mark_slot     (mark_slot)
);

`default_nettype wire

### tb/long_term_reference_slot_manager_unit_tb.sv
`timescale 1ns / 1ps

module long_term_reference_slot_manager_unit_tb;
    import ltrsm_pkg::*;

    localparam int SLOTS         = LTR_SLOT_COUNT;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = SLOTS + 6;
    localparam int PRINT_CAP     = 40;

    // One request item and the status item it produces
    typedef struct packed {
        req_t        req;
        logic [31:0] frame;
        logic [15:0] frames;
        logic        keyframe;
        logic        pic_ok;
    } ltr_request_t;

    typedef struct packed {
        logic        ok;
        logic        use_ltr;
        logic [3:0]  use_mask;
        logic [15:0] refresh;
        logic        mark_ltr;
        logic [1:0]  mark_slot;
    } ltr_status_t;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        in_valid         = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type         = REQ_MARK;
    logic [31:0] frame_id         = '0;
    logic [15:0] refresh_frames   = '0;
    logic        force_keyframe   = 1'b0;
    logic        picture_accepted = 1'b0;
    logic        out_valid;
    logic        out_stall        = 1'b0;
    logic        accepted;
    logic        use_ltr;
    logic [3:0]  use_mask;
    logic [15:0] refresh_count;
    logic        mark_ltr;
    logic [1:0]  mark_slot;
    logic        cfg_valid        = 1'b0;
    logic        cfg_ready;
    logic        cfg_index        = CFG_SLOTS;
    logic [2:0]  cfg_data         = '0;

    // Shadow copy of the slot ring, pending settings and registers
    logic [31:0] ring_id [SLOTS];
    logic        ring_live [SLOTS];
    int unsigned ring_next;
    logic        mark_due;
    logic [1:0]  mark_due_slot;
    logic [31:0] mark_due_frame;
    logic        use_due;
    logic [3:0]  use_due_mask;
    logic [15:0] refresh_due;
    int unsigned slots_reg;
    logic        refresh_reg;

    ltr_status_t status_due[$];
    int unsigned mismatch_count = 0;
    int unsigned status_checked = 0;
    int unsigned requests_sent  = 0;
    int unsigned cfg_writes     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned stall_left     = 0;
    logic        tx_idle        = 1'b0;
    logic        rx_idle        = 1'b0;
    logic [31:0] frame_clock    = '0;

    long_term_reference_slot_manager_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .frame_id         (frame_id),
        .refresh_frames   (refresh_frames),
        .force_keyframe   (force_keyframe),
        .picture_accepted (picture_accepted),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .accepted         (accepted),
        .use_ltr          (use_ltr),
        .use_mask         (use_mask),
        .refresh_count    (refresh_count),
        .mark_ltr         (mark_ltr),
        .mark_slot        (mark_slot),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Shadow model
    function automatic void clear_ring();
        for (int i = 0; i < SLOTS; i++)
        begin
            ring_id[i]   = '0;
            ring_live[i] = 1'b0;
        end
        ring_next = 0;
    endfunction

    function automatic void shadow_reset();
        clear_ring();
        mark_due       = 1'b0;
        mark_due_slot  = '0;
        mark_due_frame = '0;
        use_due        = 1'b0;
        use_due_mask   = '0;
        refresh_due    = '0;
        slots_reg      = 0;
        refresh_reg    = 1'b0;
    endfunction

    // Status for one request; advances the shadow state
    function automatic ltr_status_t ltr_status_for(ltr_request_t r);
        ltr_status_t s;
        int unsigned n;
        int unsigned cur;
        int unsigned best;
        s = '0;
        n = (slots_reg > SLOTS) ? SLOTS : slots_reg;
        case (r.req)
            REQ_MARK:
            begin
                if (n != 0)
                begin
                    cur            = (ring_next < n) ? ring_next : 0;
                    mark_due_slot  = cur[1:0];
                    ring_next      = (cur + 1) % n;
                    mark_due_frame = r.frame;
                    mark_due       = 1'b1;
                    s.ok           = 1'b1;
                end
            end
            REQ_INVAL:
            begin
                if (n != 0)
                begin
                    best = n;
                    for (int i = 0; i < n; i++)
                    begin
                        if (ring_live[i])
                        begin
                            // drop at/above threshold; strict compare keeps lower index on ties
                            if (ring_id[i] >= r.frame)
                                ring_live[i] = 1'b0;
                            else if (best == n || ring_id[i] > ring_id[best])
                                best = i;
                        end
                    end
                    if (best != n)
                    begin
                        use_due      = 1'b1;
                        use_due_mask = 4'(1 << best);
                        s.ok         = 1'b1;
                    end
                end
            end
            REQ_REFRESH:
            begin
                if (refresh_reg && r.frames != 0)
                begin
                    refresh_due = r.frames;
                    s.ok        = 1'b1;
                end
            end
            default:
            begin
                s.use_ltr   = use_due;
                s.use_mask  = use_due ? use_due_mask : '0;
                s.refresh   = refresh_due;
                s.mark_ltr  = mark_due;
                s.mark_slot = mark_due ? mark_due_slot : '0;
                s.ok        = r.pic_ok;
                // commit only when the encode went through
                if (r.pic_ok)
                begin
                    use_due      = 1'b0;
                    use_due_mask = '0;
                    refresh_due  = '0;
                    if (r.keyframe)
                        for (int i = 0; i < SLOTS; i++)
                            ring_live[i] = 1'b0;
                    if (mark_due)
                    begin
                        ring_id[mark_due_slot]   = mark_due_frame;
                        ring_live[mark_due_slot] = 1'b1;
                        mark_due                 = 1'b0;
                    end
                end
            end
        endcase
        return s;
    endfunction

    function automatic ltr_request_t make_request(req_t req, logic [31:0] frame,
                                                  logic [15:0] frames, logic keyframe,
                                                  logic pic_ok);
        ltr_request_t r;
        r.req      = req;
        r.frame    = frame;
        r.frames   = frames;
        r.keyframe = keyframe;
        r.pic_ok   = pic_ok;
        return r;
    endfunction

    // Random request, mostly ids near the running frame number so slots get hit
    function automatic ltr_request_t random_request();
        ltr_request_t r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.req = REQ_MARK;
        else if (pick < 50)
            r.req = REQ_INVAL;
        else if (pick < 62)
            r.req = REQ_REFRESH;
        else
            r.req = REQ_PICTURE;

        pick = $urandom_range(0, 9);
        if (pick == 0)
            r.frame = $urandom;
        else if (pick == 1)
            r.frame = ($urandom_range(0, 1) != 0) ? '1 : '0;
        else if (r.req == REQ_INVAL)
            r.frame = frame_clock - $urandom_range(0, 10);
        else
            r.frame = frame_clock - $urandom_range(0, 2);

        pick = $urandom_range(0, 9);
        if (pick == 0)
            r.frames = '0;
        else if (pick == 1)
            r.frames = '1;
        else
            r.frames = 16'($urandom_range(0, 65535));

        r.keyframe = ($urandom_range(0, 9) == 0);
        r.pic_ok   = ($urandom_range(0, 4) != 0);
        if (r.req == REQ_PICTURE)
            frame_clock = frame_clock + 1;
        return r;
    endfunction

    // Sender: optional gap, then hold the item until it is taken
    task automatic send_request(input ltr_request_t r);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        req_type         <= r.req;
        frame_id         <= r.frame;
        refresh_frames   <= r.frames;
        force_keyframe   <= r.keyframe;
        picture_accepted <= r.pic_ok;
        do @(posedge clk); while (in_stall);
        status_due.push_back(ltr_status_for(r));
        requests_sent++;
    endtask

    // Stop sending and wait until every status item is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [2:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SLOTS)
        begin
            slots_reg = value;
            clear_ring();
        end
        else
            refresh_reg = value[0];
        cfg_writes++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_status();
        ltr_status_t want;
        if (status_due.size() == 0)
        begin
            report_mismatch("status item with none expected", 0, 0);
            return;
        end
        want = status_due.pop_front();
        status_checked++;
        if (accepted !== want.ok)
            report_mismatch("accepted", accepted, want.ok);
        if (use_ltr !== want.use_ltr)
            report_mismatch("use_ltr", use_ltr, want.use_ltr);
        if (use_mask !== want.use_mask)
            report_mismatch("use_mask", use_mask, want.use_mask);
        if (refresh_count !== want.refresh)
            report_mismatch("refresh_count", refresh_count, want.refresh);
        if (mark_ltr !== want.mark_ltr)
            report_mismatch("mark_ltr", mark_ltr, want.mark_ltr);
        if (mark_slot !== want.mark_slot)
            report_mismatch("mark_slot", mark_slot, want.mark_slot);
    endtask

    // Receiver: check each taken item, then, when rx_idle is set, stall for a random stretch
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_status();
            stall_left = rx_idle ? $urandom_range(0, 4) : 0;
        end
        else if (stall_left != 0)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Everything rejected at reset settings; pictures still report and commit
    task automatic test_disabled_requests();
        send_request(make_request(REQ_MARK, 32'h1234_5678, '1, 1'b1, 1'b1));
        send_request(make_request(REQ_INVAL, '1, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_REFRESH, '0, '1, 1'b0, 1'b1));
        send_request(make_request(REQ_PICTURE, '0, '0, 1'b1, 1'b0));
        send_request(make_request(REQ_PICTURE, '1, '1, 1'b0, 1'b1));
    endtask

    // Marks, overwrite, tie on invalidate, refresh, rejected picture, keyframe
    task automatic test_ring_marks();
        write_register(CFG_SLOTS, 3'd4);
        write_register(CFG_REFRESH, 3'd1);
        send_request(make_request(REQ_MARK, '1, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_PICTURE, '0, '0, 1'b0, 1'b1));
        send_request(make_request(REQ_MARK, '0, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_PICTURE, '0, '0, 1'b0, 1'b1));
        // later mark replaces the pending one, ring still advances
        send_request(make_request(REQ_MARK, 32'd50, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_MARK, 32'd50, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_PICTURE, '0, '0, 1'b0, 1'b1));
        send_request(make_request(REQ_MARK, 32'd50, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_PICTURE, '0, '0, 1'b0, 1'b1));
        // equal ids: lower slot wins
        send_request(make_request(REQ_INVAL, '1, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_REFRESH, '0, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_REFRESH, '0, '1, 1'b0, 1'b0));
        send_request(make_request(REQ_MARK, 32'd9, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_PICTURE, '0, '0, 1'b1, 1'b0));
        // keyframe wipes the ring but the pending mark lands afterwards
        send_request(make_request(REQ_PICTURE, '0, '0, 1'b1, 1'b1));
        send_request(make_request(REQ_INVAL, 32'd10, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_INVAL, '0, '0, 1'b0, 1'b0));
        send_request(make_request(REQ_PICTURE, '0, '0, 1'b0, 1'b1));
        send_request(make_request(REQ_REFRESH, '0, 16'd1, 1'b0, 1'b0));
    endtask

    // Pending mark survives a slot count write; count above the ring saturates
    task automatic test_count_change();
        send_request(make_request(REQ_MARK, 32'd5, '0, 1'b0, 1'b0));
        write_register(CFG_SLOTS, 3'd7);
        send_request(make_request(REQ_PICTURE, '0, '0, 1'b0, 1'b1));
        send_request(make_request(REQ_INVAL, 32'd6, '0, 1'b0, 1'b0));
        write_register(CFG_REFRESH, 3'd6);
        send_request(make_request(REQ_REFRESH, '0, 16'h8000, 1'b0, 1'b0));
    endtask

    // Random traffic over a sweep of slot counts and idling modes
    task automatic test_random_traffic();
        logic [2:0] counts [9];
        counts = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd7, 3'd5, 3'd0, 3'd6, 3'd4};
        for (int p = 0; p < 9; p++)
        begin
            write_register(CFG_SLOTS, counts[p]);
            write_register(CFG_REFRESH, 3'($urandom_range(0, 7)));
            tx_idle     = (p != 0) && ($urandom_range(0, 3) != 0);
            rx_idle     = (p != 0) && ($urandom_range(0, 3) != 0);
            frame_clock = (p % 2 == 0) ? 32'd0 : $urandom;
            for (int k = 0; k < 222; k++)
            begin
                send_request(random_request());
                // hold off once mid-phase until every status item is back
                if (p == 3 && k == 100)
                    drain_results();
            end
        end
    endtask

    initial
    begin
        shadow_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_requests();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_ring_marks();
        test_count_change();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d requests and %0d register writes over slot counts 0 to 7,",
                 requests_sent, cfg_writes);
        $display("with %0d status items checked against the shadow ring.", status_checked);
        if (mismatch_count == 0 && status_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
